// File: design/dpsa_pkg.sv
// ----------------------------------------------------------------------------
// dpsa_pkg
// Shared widths, constants and lookups for the docking pair score
// accumulator: radius table, fixed-point limits and term slot names.
// ----------------------------------------------------------------------------
package dpsa_pkg;

    localparam int ACCUM_BITS_DEF  = 40;
    localparam int EXP_ENTRIES_DEF = 1024;

    localparam int DIST_W    = 16;
    localparam int ELEM_W    = 4;
    localparam int RAD_W     = 14;
    localparam int DIFF_W    = 17;
    localparam int MAG_W     = 16;
    localparam int SQ_W      = 32;
    localparam int TERM_W    = 17;
    localparam int EXP_W     = 13;
    localparam int SUM_OUT_W = 40;
    localparam int FRAC_W    = 12;
    localparam int HB_Q_W    = 12;
    localparam int HB_NUM_W  = 24;
    localparam int MUL_A_W   = 30;
    localparam int MUL_B_W   = 25;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;

    localparam int NEAR_SHIFT = 26;
    localparam int FAR_SHIFT  = 30;
    localparam int HB_SHIFT   = 36;
    localparam int HB_DIV     = 2867;
    localparam int NUM_TERMS  = 5;

    localparam logic [DIST_W-1:0]        CUTOFF_RESET = 16'd32768;
    localparam logic signed [DIFF_W-1:0] FAR_OFFSET   = 17'sd12288;
    localparam logic signed [DIFF_W-1:0] HYD_ZERO_AT  = 17'sd6144;
    localparam logic signed [DIFF_W-1:0] HYD_FULL_AT  = 17'sd2048;
    localparam logic signed [DIFF_W-1:0] HB_FULL_AT   = -17'sd2867;
    localparam logic [TERM_W-1:0]        ONE_Q12      = 17'd4096;
    localparam logic [SQ_W:0]            REP_ROUND    = 33'd2048;
    localparam logic [HB_NUM_W-1:0]      HB_ROUND     = 24'd1433;

    // ceil(2^36 / 2867): exact quotient for every numerator below 2^24
    localparam logic [63:0] HB_RECIP_WIDE =
        ((64'd1 << HB_SHIFT) + 64'(HB_DIV) - 64'd1) / 64'(HB_DIV);
    localparam logic [MUL_B_W-1:0] HB_RECIP = HB_RECIP_WIDE[MUL_B_W-1:0];

    typedef enum logic [ELEM_W-1:0] {
        ELEM_C     = 4'd0,
        ELEM_N     = 4'd1,
        ELEM_O     = 4'd2,
        ELEM_S     = 4'd3,
        ELEM_P     = 4'd4,
        ELEM_F     = 4'd5,
        ELEM_CL    = 4'd6,
        ELEM_BR    = 4'd7,
        ELEM_I     = 4'd8,
        ELEM_OTHER = 4'd9
    } elem_t;

    typedef enum logic [2:0] {
        TERM_NEAR = 3'd0,
        TERM_FAR  = 3'd1,
        TERM_REP  = 3'd2,
        TERM_HYD  = 3'd3,
        TERM_HB   = 3'd4
    } term_t;

    function automatic logic [RAD_W-1:0] vdw_radius(input logic [ELEM_W-1:0] elem);
        logic [RAD_W-1:0] rad;
        unique case (elem)
            ELEM_C:  rad = 14'd7782;
            ELEM_N:  rad = 14'd7373;
            ELEM_O:  rad = 14'd6963;
            ELEM_S:  rad = 14'd8192;
            ELEM_P:  rad = 14'd8602;
            ELEM_F:  rad = 14'd6144;
            ELEM_CL: rad = 14'd7373;
            ELEM_BR: rad = 14'd8192;
            ELEM_I:  rad = 14'd9011;
            default: rad = 14'd4915;
        endcase
        return rad;
    endfunction

endpackage

// File: design/docking_pair_score_accumulator_unit.sv
// ----------------------------------------------------------------------------
// docking_pair_score_accumulator_unit
// Scores receptor/ligand atom pairs with five empirical terms and keeps
// saturating per-pose sums, emitted and cleared on the last pair.
// ----------------------------------------------------------------------------
//  channel | signals                                   | moves
//  --------+-------------------------------------------+---------------------
//  in      | in_valid / in_stall, pair fields          | one pair request
//  out     | out_valid / out_stall, five sums, flag    | one pose result
//  cfg     | cfg_write_en / cfg_write_data             | cutoff distance
//
//  A scored pair runs through seven steps (ST_NSQ to ST_HBA) before the next
//  acceptance; one shared 30x25 multiplier and one exp ROM port serve them.
//  A pair that is skipped (no pair, or beyond cutoff) is not scored.
//  A last pair then loads the result in ST_DONE, which waits while out is stalled.
//  The result register lets the next pose start while a result waits.
//  Reset sets the cutoff to 8.0 A and clears sums and flag; no clearing pass.
// ----------------------------------------------------------------------------
module docking_pair_score_accumulator_unit
    import dpsa_pkg::*;
#(
    parameter int ACCUM_BITS        = ACCUM_BITS_DEF,
    parameter int EXP_TABLE_ENTRIES = EXP_ENTRIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [DIST_W-1:0]    cfg_write_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 pair_valid,
    input  logic [ELEM_W-1:0]    element_a,
    input  logic [ELEM_W-1:0]    element_b,
    input  logic                 hydrophobic_a,
    input  logic                 hydrophobic_b,
    input  logic                 donor_a,
    input  logic                 donor_b,
    input  logic                 acceptor_a,
    input  logic                 acceptor_b,
    input  logic [DIST_W-1:0]    pair_distance,
    input  logic                 last_pair,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SUM_OUT_W-1:0] gauss_near_sum,
    output logic [SUM_OUT_W-1:0] gauss_far_sum,
    output logic [SUM_OUT_W-1:0] repulsion_sum,
    output logic [SUM_OUT_W-1:0] hydrophobic_sum,
    output logic [SUM_OUT_W-1:0] hbond_sum,
    output logic                 saturated
);

    localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES);
    localparam logic [63:0] EXP_STEP = (64'd1 << 36) / 64'(EXP_TABLE_ENTRIES);

    typedef logic [EXP_W-1:0] exp_rom_t [EXP_TABLE_ENTRIES];

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_NSQ  = 9'b000000010,
        ST_NIDX = 9'b000000100,
        ST_NRD  = 9'b000001000,
        ST_FIDX = 9'b000010000,
        ST_FRD  = 9'b000100000,
        ST_FACC = 9'b001000000,
        ST_HBA  = 9'b010000000,
        ST_DONE = 9'b100000000
    } state_t;

    function automatic exp_rom_t build_exp_rom();
        exp_rom_t rom;
        logic [63:0] f;
        logic [63:0] t;
        logic [63:0] e;
        int i;
        f = 64'd1 << 32;
        t = 64'd1 << 32;
        e = 64'd1 << 32;
        t = ((t * EXP_STEP) >> 32) / 64'd1;  f = f - t;
        t = ((t * EXP_STEP) >> 32) / 64'd2;  f = f + t;
        t = ((t * EXP_STEP) >> 32) / 64'd3;  f = f - t;
        t = ((t * EXP_STEP) >> 32) / 64'd4;  f = f + t;
        t = ((t * EXP_STEP) >> 32) / 64'd5;  f = f - t;
        t = ((t * EXP_STEP) >> 32) / 64'd6;  f = f + t;
        t = ((t * EXP_STEP) >> 32) / 64'd7;  f = f - t;
        t = ((t * EXP_STEP) >> 32) / 64'd8;  f = f + t;
        t = ((t * EXP_STEP) >> 32) / 64'd9;  f = f - t;
        t = ((t * EXP_STEP) >> 32) / 64'd10; f = f + t;
        for (i = 0; i < EXP_TABLE_ENTRIES; i++)
        begin
            rom[i] = EXP_W'((e + (64'd1 << 19)) >> 20);
            e = (e * f + (64'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

    state_t state_reg, state_next;

    logic [DIST_W-1:0]        cutoff_reg;
    logic signed [DIFF_W-1:0] d_reg, d_next;
    logic                     last_reg, last_next;
    logic                     hyd_en_reg, hyd_en_next;
    logic                     hb_en_reg, hb_en_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [TERM_W-1:0]        rep_reg, rep_next;
    logic                     near_zero_reg, near_zero_next;
    logic                     far_zero_reg, far_zero_next;
    logic [EXP_W-1:0]         exp_q_reg;
    logic [ACCUM_BITS-1:0]    sums_reg [NUM_TERMS];
    logic [ACCUM_BITS-1:0]    sums_next [NUM_TERMS];
    logic                     overflow_reg, overflow_next;
    logic                     out_valid_reg, out_valid_next;
    logic [SUM_OUT_W-1:0]     out_sum_reg [NUM_TERMS];
    logic                     out_sat_reg;

    logic                     in_accept;
    logic                     active_in;
    logic [RAD_W:0]           rad_sum;
    logic [DIFF_W-1:0]        diff_in;
    logic                     d_neg;
    logic [DIFF_W-1:0]        neg_d;
    logic [MAG_W-1:0]         abs_d;
    logic signed [DIFF_W-1:0] x_val;
    logic [DIFF_W-1:0]        neg_x;
    logic [MAG_W-1:0]         abs_x;
    logic [HB_NUM_W-1:0]      hb_num;
    logic [SQ_W:0]            rep_wide;
    logic [TERM_W-1:0]        hyd_term;
    logic [TERM_W-1:0]        hb_term;
    logic [TERM_W-1:0]        exp_term;
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic                     mul_en;
    logic [IDX_W-1:0]         rom_addr;
    logic                     acc_en;
    term_t                    acc_sel;
    logic [TERM_W-1:0]        acc_term;
    logic [ACCUM_BITS:0]      acc_wide;
    logic                     emit_go;
    logic [ACCUM_BITS+SUM_OUT_W-1:0] sum_pad [NUM_TERMS];

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign active_in = pair_valid && (pair_distance <= cutoff_reg);
    assign rad_sum   = {1'b0, vdw_radius(element_a)} + {1'b0, vdw_radius(element_b)};
    assign diff_in   = {1'b0, pair_distance} - {{(DIFF_W-RAD_W-1){1'b0}}, rad_sum};

    assign d_neg  = d_reg[DIFF_W-1];
    assign neg_d  = DIFF_W'(-d_reg);
    assign abs_d  = d_neg ? neg_d[MAG_W-1:0] : d_reg[MAG_W-1:0];
    assign x_val  = d_reg - FAR_OFFSET;
    assign neg_x  = DIFF_W'(-x_val);
    assign abs_x  = x_val[DIFF_W-1] ? neg_x[MAG_W-1:0] : x_val[MAG_W-1:0];
    assign hb_num = {neg_d[HB_Q_W-1:0], {FRAC_W{1'b0}}} + HB_ROUND;

    assign rep_wide = {1'b0, prod_reg[SQ_W-1:0]} + REP_ROUND;
    assign rep_next = d_neg ? rep_wide[FRAC_W +: TERM_W] : '0;
    assign near_zero_next = (prod_reg[SQ_W-1:NEAR_SHIFT] != '0);
    assign far_zero_next  = (prod_reg[SQ_W-1:FAR_SHIFT] != '0);

    assign exp_term = {{(TERM_W-EXP_W){1'b0}}, exp_q_reg};

    always_comb
    begin
        hyd_term = '0;
        if (hyd_en_reg)
        begin
            priority if (d_reg >= HYD_ZERO_AT)
                hyd_term = '0;
            else if (d_reg <= HYD_FULL_AT)
                hyd_term = ONE_Q12;
            else
                hyd_term = TERM_W'($unsigned(HYD_ZERO_AT - d_reg));
        end
    end

    always_comb
    begin
        hb_term = '0;
        if (hb_en_reg)
        begin
            priority if (!d_neg)
                hb_term = '0;
            else if (d_reg <= HB_FULL_AT)
                hb_term = ONE_Q12;
            else
                hb_term = {{(TERM_W-HB_Q_W){1'b0}}, prod_reg[HB_SHIFT +: HB_Q_W]};
        end
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_en = 1'b1;
        unique case (state_reg)
            ST_NSQ:
            begin
                mul_a = MUL_A_W'(abs_d);
                mul_b = MUL_B_W'(abs_d);
            end
            ST_NIDX:
            begin
                mul_a = MUL_A_W'(prod_reg[NEAR_SHIFT-1:0]);
                mul_b = MUL_B_W'(EXP_TABLE_ENTRIES);
            end
            ST_NRD:
            begin
                mul_a = MUL_A_W'(abs_x);
                mul_b = MUL_B_W'(abs_x);
            end
            ST_FIDX:
            begin
                mul_a = prod_reg[FAR_SHIFT-1:0];
                mul_b = MUL_B_W'(EXP_TABLE_ENTRIES);
            end
            ST_FRD:
            begin
                mul_a = MUL_A_W'(hb_num);
                mul_b = HB_RECIP;
            end
            default:
            begin
                mul_en = 1'b0;
                mul_a  = '0;
                mul_b  = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        unique case (state_reg)
            ST_NRD:  rom_addr = prod_reg[NEAR_SHIFT +: IDX_W];
            ST_FRD:  rom_addr = prod_reg[FAR_SHIFT +: IDX_W];
            default: rom_addr = '0;
        endcase
    end

    // Shared saturating accumulator select
    always_comb
    begin
        acc_en   = 1'b1;
        acc_sel  = TERM_NEAR;
        acc_term = '0;
        unique case (state_reg)
            ST_NRD:
            begin
                acc_sel  = TERM_REP;
                acc_term = rep_reg;
            end
            ST_FIDX:
            begin
                acc_sel  = TERM_NEAR;
                acc_term = near_zero_reg ? '0 : exp_term;
            end
            ST_FRD:
            begin
                acc_sel  = TERM_HYD;
                acc_term = hyd_term;
            end
            ST_FACC:
            begin
                acc_sel  = TERM_FAR;
                acc_term = far_zero_reg ? '0 : exp_term;
            end
            ST_HBA:
            begin
                acc_sel  = TERM_HB;
                acc_term = hb_term;
            end
            default:
            begin
                acc_en = 1'b0;
            end
        endcase
    end

    assign acc_wide = {1'b0, sums_reg[acc_sel]} + (ACCUM_BITS+1)'(acc_term);
    assign emit_go  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        overflow_next = overflow_reg;
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            sums_next[k] = sums_reg[k];
        end
        if (emit_go)
        begin
            overflow_next = 1'b0;
            for (int k = 0; k < NUM_TERMS; k++)
            begin
                sums_next[k] = '0;
            end
        end
        else if (acc_en)
        begin
            if (acc_wide[ACCUM_BITS])
            begin
                sums_next[acc_sel] = '1;
                overflow_next      = 1'b1;
            end
            else
            begin
                sums_next[acc_sel] = acc_wide[ACCUM_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        d_next      = d_reg;
        last_next   = last_reg;
        hyd_en_next = hyd_en_reg;
        hb_en_next  = hb_en_reg;
        if (in_accept)
        begin
            d_next      = $signed(diff_in);
            last_next   = last_pair;
            hyd_en_next = hydrophobic_a && hydrophobic_b;
            hb_en_next  = (donor_a && acceptor_b) || (donor_b && acceptor_a);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_go)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    priority if (active_in)
                        state_next = ST_NSQ;
                    else if (last_pair)
                        state_next = ST_DONE;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_NSQ:  state_next = ST_NIDX;
            ST_NIDX: state_next = ST_NRD;
            ST_NRD:  state_next = ST_FIDX;
            ST_FIDX: state_next = ST_FRD;
            ST_FRD:  state_next = ST_FACC;
            ST_FACC: state_next = ST_HBA;
            ST_HBA:  state_next = last_reg ? ST_DONE : ST_IDLE;
            ST_DONE: state_next = emit_go ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cutoff_reg    <= CUTOFF_RESET;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_TERMS; k++)
            begin
                sums_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < NUM_TERMS; k++)
            begin
                sums_reg[k] <= sums_next[k];
            end
            if (cfg_write_en)
                cutoff_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        last_reg   <= last_next;
        hyd_en_reg <= hyd_en_next;
        hb_en_reg  <= hb_en_next;
        exp_q_reg  <= EXP_ROM[rom_addr];
        if (mul_en)
            prod_reg <= prod_next;
        if (state_reg == ST_NIDX)
        begin
            rep_reg       <= rep_next;
            near_zero_reg <= near_zero_next;
        end
        if (state_reg == ST_FIDX)
            far_zero_reg <= far_zero_next;
        if (emit_go)
        begin
            out_sat_reg <= overflow_reg;
            for (int k = 0; k < NUM_TERMS; k++)
            begin
                out_sum_reg[k] <= sum_pad[k][SUM_OUT_W-1:0];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            sum_pad[k] = {{SUM_OUT_W{1'b0}}, sums_reg[k]};
        end
    end

    assign out_valid       = out_valid_reg;
    assign gauss_near_sum  = out_sum_reg[TERM_NEAR];
    assign gauss_far_sum   = out_sum_reg[TERM_FAR];
    assign repulsion_sum   = out_sum_reg[TERM_REP];
    assign hydrophobic_sum = out_sum_reg[TERM_HYD];
    assign hbond_sum       = out_sum_reg[TERM_HB];
    assign saturated       = out_sat_reg;

`ifndef ASSERT_OFF
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> (!overflow_reg && sums_reg[TERM_NEAR] == '0
                     && sums_reg[TERM_FAR] == '0 && sums_reg[TERM_REP] == '0
                     && sums_reg[TERM_HYD] == '0 && sums_reg[TERM_HB] == '0))
        else $error("sums not cleared after result load");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside of the emit step");

    a_empty_request_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !pair_valid && !last_pair) |=> (state_reg == ST_IDLE))
        else $error("empty request started a scoring pass");
`endif

endmodule
